[rtl/label_rank_table_unit_defines.svh]
// ----------------------------------------------------------------------------
// Label rank table assertion macros
// Shared helpers for the concurrent checks in the label rank table modules.
// ----------------------------------------------------------------------------
`ifndef LABEL_RANK_TABLE_UNIT_DEFINES_SVH
`define LABEL_RANK_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define LRT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define LRT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/lrt_pkg.sv]
// ----------------------------------------------------------------------------
// Label rank table package
// Field widths, request codes, default sizes and the controller command type.
// ----------------------------------------------------------------------------
package lrt_pkg;

	localparam int MAX_REGIONS_DEF = 64;
	localparam int LABEL_BITS_DEF  = 16;

	localparam int REQ_W   = 2;
	localparam int LABEL_W = 16;
	localparam int INDEX_W = 6;
	localparam int COUNT_W = 7;

	localparam logic [REQ_W-1:0] REQ_COLLECT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_MAP     = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // capture the incoming request
		logic eval;    // compare the label against every held entry
		logic commit;  // update the table and load the result register
	} cmd_t;

endpackage

[rtl/lrt_ctrl.sv]
// ----------------------------------------------------------------------------
// Label rank table controller
// Sequences each request through compare and commit and owns the handshakes.
// ----------------------------------------------------------------------------
`include "label_rank_table_unit_defines.svh"

module lrt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	output lrt_pkg::cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EVAL = 2'd1;
	localparam logic [1:0] S_UPD  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic       out_valid_q;
	logic       out_free;
	logic       accept;
	logic       commit;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = !((state_q == S_IDLE) || ((state_q == S_UPD) && out_free));
	assign accept    = in_valid && !in_stall;
	assign commit    = (state_q == S_UPD) && out_free;
	assign out_valid = out_valid_q;

	assign cmd.load   = accept;
	assign cmd.eval   = (state_q == S_EVAL);
	assign cmd.commit = commit;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_nxt = S_EVAL;
			end
			S_EVAL: begin
				state_nxt = S_UPD;
			end
			S_UPD: begin
				// A new request may enter in the same cycle the last one commits.
				if (commit) state_nxt = accept ? S_EVAL : S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`LRT_ASSERT_NOW(a_accept_state, accept, (state_q == S_IDLE) || (state_q == S_UPD),
		"request accepted while busy")
	`LRT_ASSERT_NEXT(a_eval_then_upd, state_q == S_EVAL, state_q == S_UPD,
		"compare not followed by commit")
	`LRT_ASSERT_NOW(a_result_source, $rose(out_valid_q), $past(state_q) == S_UPD,
		"result without a commit")

endmodule

[rtl/lrt_datapath.sv]
// ----------------------------------------------------------------------------
// Label rank table datapath
// Holds the sorted label cells, compares in parallel and inserts by shifting.
// ----------------------------------------------------------------------------
`include "label_rank_table_unit_defines.svh"

module lrt_datapath #(
	parameter int MAX_REGIONS = lrt_pkg::MAX_REGIONS_DEF,
	parameter int LABEL_BITS  = lrt_pkg::LABEL_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lrt_pkg::cmd_t               cmd,
	input  logic [lrt_pkg::REQ_W-1:0]   req_type,
	input  logic [lrt_pkg::LABEL_W-1:0] label,
	output logic [lrt_pkg::INDEX_W-1:0] region_index,
	output logic [lrt_pkg::COUNT_W-1:0] region_count,
	output logic                        found,
	output logic                        overflow
);

	localparam int CW = $clog2(MAX_REGIONS + 1);

	logic [LABEL_BITS-1:0]       tab_q [MAX_REGIONS];
	logic [LABEL_BITS-1:0]       tab_prev [MAX_REGIONS];
	logic [CW-1:0]               count_q;
	logic [CW-1:0]               count_nxt;
	logic [lrt_pkg::REQ_W-1:0]   req_q;
	logic [LABEL_BITS-1:0]       label_q;

	logic [MAX_REGIONS-1:0]      lt_c;
	logic [MAX_REGIONS-1:0]      eq_c;
	logic [MAX_REGIONS:0]        bnd_c;
	logic [CW-1:0]               rank_c;

	logic [MAX_REGIONS-1:0]      lt_s1;
	logic [MAX_REGIONS-1:0]      bnd_s1;
	logic [CW-1:0]               rank_s1;
	logic                        found_s1;

	logic                        do_insert;
	logic                        full;
	logic [CW-1:0]               idx_c;
	logic                        fnd_c;
	logic                        ovf_c;

	// Only entries below the fill count take part in the compare.
	always_comb begin
		for (int i = 0; i < MAX_REGIONS; i++) begin
			lt_c[i] = (CW'(i) < count_q) && (tab_q[i] < label_q);
			eq_c[i] = (CW'(i) < count_q) && (tab_q[i] == label_q);
		end
	end

	// The table is sorted, so the less-than flags form a thermometer code and
	// its edge marks the rank the label has or would get.
	assign bnd_c = {lt_c, 1'b1} & ~{1'b0, lt_c};

	always_comb begin
		rank_c = '0;
		for (int i = 0; i <= MAX_REGIONS; i++) begin
			if (bnd_c[i]) rank_c = rank_c | CW'(i);
		end
	end

	assign full = (count_q == CW'(MAX_REGIONS));

	always_comb begin
		do_insert = 1'b0;
		idx_c     = '0;
		fnd_c     = 1'b0;
		ovf_c     = 1'b0;
		count_nxt = count_q;
		unique case (req_q)
			lrt_pkg::REQ_COLLECT: begin
				if (found_s1) begin
					fnd_c = 1'b1;
					idx_c = rank_s1;
				end else if (!full) begin
					do_insert = 1'b1;
					idx_c     = rank_s1;
					count_nxt = count_q + CW'(1);
				end else begin
					ovf_c = 1'b1;
				end
			end
			lrt_pkg::REQ_MAP: begin
				if (found_s1) begin
					fnd_c = 1'b1;
					idx_c = rank_s1;
				end
			end
			lrt_pkg::REQ_CLEAR: begin
				count_nxt = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit) begin
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q   <= req_type;
			label_q <= LABEL_BITS'(label);
		end
		if (cmd.eval) begin
			lt_s1    <= lt_c;
			bnd_s1   <= bnd_c[MAX_REGIONS-1:0];
			rank_s1  <= rank_c;
			found_s1 <= |eq_c;
		end
		if (cmd.commit) begin
			region_index <= lrt_pkg::INDEX_W'(idx_c);
			region_count <= lrt_pkg::COUNT_W'(count_nxt);
			found        <= fnd_c;
			overflow     <= ovf_c;
		end
	end

	// Each cell either keeps its value, takes the new label, or takes the
	// value of the cell below it when the insert point lies beneath.
	for (genvar g = 0; g < MAX_REGIONS; g++) begin : g_cell
		if (g == 0) begin : g_first
			assign tab_prev[g] = label_q;
		end else begin : g_rest
			assign tab_prev[g] = tab_q[g-1];
		end

		always_ff @(posedge clk) begin
			if (cmd.commit && do_insert && !lt_s1[g]) begin
				tab_q[g] <= bnd_s1[g] ? label_q : tab_prev[g];
			end
		end
	end

	`LRT_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(MAX_REGIONS),
		"fill count beyond table size")
	`LRT_ASSERT_NEXT(a_insert_grows, cmd.commit && do_insert,
		count_q == $past(count_q) + CW'(1), "insert did not grow the table")

endmodule

[rtl/label_rank_table_unit.sv]
// ----------------------------------------------------------------------------
// Label rank table unit
// Keeps the distinct labels of a voxel stream in ascending order and maps a
// label to its rank among them.
// ----------------------------------------------------------------------------
// The input channel (in_valid / in_stall) carries req_type and label. A
// collect request inserts a new label at its sorted place or reports overflow
// when the table is full, a map request returns the rank of a held label and
// a clear request empties the table. Every request yields one result on the
// output channel (out_valid / out_stall): region_index, region_count, found
// and overflow. An accepted request is registered, compared against all
// held entries in parallel, and then committed: the shift-insert updates the
// table and the result register loads. A new request is taken in the commit
// cycle of the previous one, so the compare and commit steps alternate.
// While the receiver stalls, the result register holds and the block takes
// one more request, which waits in its commit step. Reset empties the table
// (fill count zero); the label cells are not cleared.
// ----------------------------------------------------------------------------

module label_rank_table_unit #(
	parameter int MAX_REGIONS = lrt_pkg::MAX_REGIONS_DEF,
	parameter int LABEL_BITS  = lrt_pkg::LABEL_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [lrt_pkg::REQ_W-1:0]   req_type,
	input  logic [lrt_pkg::LABEL_W-1:0] label,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [lrt_pkg::INDEX_W-1:0] region_index,
	output logic [lrt_pkg::COUNT_W-1:0] region_count,
	output logic                        found,
	output logic                        overflow
);

	lrt_pkg::cmd_t cmd;

	lrt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	lrt_datapath #(
		.MAX_REGIONS (MAX_REGIONS),
		.LABEL_BITS  (LABEL_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.req_type     (req_type),
		.label        (label),
		.region_index (region_index),
		.region_count (region_count),
		.found        (found),
		.overflow     (overflow)
	);

endmodule
